[rtl/mme_pkg.sv]
// ---------------------------------------------------------------------------
// Montgomery exponentiation package
// Shared widths, sequencer states and control structures.
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int unsigned ModWidth = 31;
  localparam int unsigned ExpWidth = 31;
  localparam int unsigned InWidth  = 31;
  // The accumulator holds values below 2M, so one guard bit is enough.
  localparam int unsigned AccWidth = ModWidth + 1;
  localparam int unsigned CntWidth = $clog2(2 * ModWidth + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONST,
    ST_REDUCE,
    ST_PM,
    ST_ZM,
    ST_ZMUL,
    ST_ZOUT,
    ST_PSQ,
    ST_POUT,
    ST_DONE
  } mme_state_e;

  // Control handed from the sequencer to the cell row.
  typedef struct packed {
    logic start;   // load operand A, clear the accumulator
    logic shift;   // run one Montgomery iteration
  } mme_row_ctrl_t;

endpackage

[rtl/mme_cell.sv]
// ---------------------------------------------------------------------------
// Montgomery cell
// One bit slice of the accumulator: adds a bit of B, a bit of M and the two
// carries, then passes its sum bit to the right-hand neighbour as the shift.
// ---------------------------------------------------------------------------
module mme_cell
  import mme_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic en_i,
  input  logic a_bit_i,
  input  logic q_bit_i,
  input  logic b_bit_i,
  input  logic m_bit_i,
  input  logic carry_i,
  input  logic mcarry_i,
  input  logic left_sum_i,
  output logic sum_o,
  output logic carry_o,
  output logic mcarry_o,
  output logic acc_o
);

  logic acc_q, acc_d;
  logic s1, ab, qm;

  // Two full adders: the accumulator bit plus the selected B bit, then M
  // when q is set. Each adder keeps its own carry chain.
  always_comb begin
    ab       = a_bit_i & b_bit_i;
    qm       = q_bit_i & m_bit_i;
    s1       = acc_q ^ ab ^ carry_i;
    carry_o  = (acc_q & ab) | (acc_q & carry_i) | (ab & carry_i);
    sum_o    = s1 ^ qm ^ mcarry_i;
    mcarry_o = (s1 & qm) | (s1 & mcarry_i) | (qm & mcarry_i);
    acc_d    = acc_q;
    if (clear_i) begin
      acc_d = 1'b0;
    end else if (en_i) begin
      acc_d = left_sum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/mme_row.sv]
// ---------------------------------------------------------------------------
// Montgomery cell row
// A row of cells that computes A*B*R^-1 mod M one bit of A per cycle while shift is set.
// ---------------------------------------------------------------------------
module mme_row
  import mme_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mme_row_ctrl_t       ctrl_i,
  input  logic [ModWidth-1:0] a_i,
  input  logic [ModWidth-1:0] b_i,
  input  logic [ModWidth-1:0] m_i,
  output logic [ModWidth-1:0] res_o
);

  logic [ModWidth-1:0] a_q, a_d;
  logic [AccWidth-1:0] sum, acc;
  logic [AccWidth:0]   carry;
  logic [AccWidth:0]   mcarry;
  logic [AccWidth-1:0] bx, mx;
  logic                q_bit;
  logic [AccWidth:0]   diff;

  assign bx = {1'b0, b_i};
  assign mx = {1'b0, m_i};
  // Parity of acc + a0*B decides whether M is added.
  assign q_bit = acc[0] ^ (a_q[0] & b_i[0]);
  assign carry[0]  = 1'b0;
  assign mcarry[0] = 1'b0;

  // Operand A shifts right, one bit consumed each iteration.
  always_comb begin
    a_d = a_q;
    if (ctrl_i.start) begin
      a_d = a_i;
    end else if (ctrl_i.shift) begin
      a_d = a_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  // Cell chain; the top cell takes the final carry as its shifted-in bit.
  // The full sum stays below 4M, so at most one of the two carries is set.
  for (genvar g = 0; g < AccWidth; g++) begin : g_cell
    logic left;
    if (g == AccWidth - 1) begin : g_top
      assign left = carry[AccWidth] | mcarry[AccWidth];
    end else begin : g_mid
      assign left = sum[g+1];
    end
    mme_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (ctrl_i.start),
      .en_i       (ctrl_i.shift),
      .a_bit_i    (a_q[0]),
      .q_bit_i    (q_bit),
      .b_bit_i    (bx[g]),
      .m_bit_i    (mx[g]),
      .carry_i    (carry[g]),
      .mcarry_i   (mcarry[g]),
      .left_sum_i (left),
      .sum_o      (sum[g]),
      .carry_o    (carry[g+1]),
      .mcarry_o   (mcarry[g+1]),
      .acc_o      (acc[g])
    );
  end

  // Final conditional subtraction of M.
  always_comb begin
    diff  = {1'b0, acc} - {2'b00, m_i};
    res_o = diff[AccWidth] ? acc[ModWidth-1:0] : diff[ModWidth-1:0];
  end

endmodule

[rtl/mme_seq.sv]
// ---------------------------------------------------------------------------
// Exponentiation sequencer
// Runs the R^2 constant computation, base reduction and the right-to-left
// exponent scan, issuing products to the cell row.
// ---------------------------------------------------------------------------
module mme_seq
  import mme_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ModWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InWidth-1:0]  base_i,
  input  logic [InWidth-1:0]  exponent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [InWidth-1:0]  power_mod_o,
  output mme_row_ctrl_t       row_ctrl_o,
  output logic [ModWidth-1:0] row_a_o,
  output logic [ModWidth-1:0] row_b_o,
  output logic [ModWidth-1:0] row_m_o,
  input  logic [ModWidth-1:0] row_res_i
);

  mme_state_e state_q, state_d;
  logic [ModWidth-1:0] mod_q, mod_d;
  logic [ModWidth-1:0] r2_q, r2_d;
  logic [ModWidth-1:0] p_q, p_d, pm_q, pm_d, z_q, z_d;
  logic [ExpWidth-1:0] e_q, e_d;
  logic [InWidth:0]    rem_q, rem_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [CntWidth-1:0] nbits_q, nbits_d;
  logic                busy_q, busy_d;
  logic                const_q, const_d;
  logic [ModWidth-1:0] one_m;
  logic [ModWidth:0]   dbl;
  logic [ModWidth:0]   dsub;
  logic [InWidth:0]    rsub;
  logic [InWidth:0]    mshift;
  logic                out_valid_q, out_valid_d;
  logic [InWidth-1:0]  out_q, out_d;
  logic                mul_done;
  logic [CntWidth-1:0] bitlen;

  assign one_m = (mod_q == ModWidth'(1)) ? '0 : ModWidth'(1);

  // Bit length of the modulus.
  always_comb begin
    bitlen = '0;
    for (int i = 0; i < ModWidth; i++) begin
      if (mod_q[i]) begin
        bitlen = CntWidth'(i + 1);
      end
    end
  end

  // Doubling step of the R^2 computation.
  assign dbl  = {r2_q, 1'b0};
  assign dsub = dbl - {1'b0, mod_q};
  // Restoring step of the base reduction: the modulus shifted left by cnt_q
  // is subtracted if it fits.
  assign mshift = {1'b0, mod_q} << cnt_q;
  assign rsub   = rem_q - mshift;

  assign mul_done = (cnt_q == nbits_q);
  assign row_m_o  = mod_q;
  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CONST;
      mod_q       <= ModWidth'(3);
      busy_q      <= 1'b1;
      const_q     <= 1'b1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      nbits_q     <= '0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      busy_q      <= busy_d;
      const_q     <= const_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      nbits_q     <= nbits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q  <= r2_d;
    p_q   <= p_d;
    pm_q  <= pm_d;
    z_q   <= z_d;
    e_q   <= e_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    r2_d        = r2_q;
    p_d         = p_q;
    pm_d        = pm_q;
    z_d         = z_q;
    e_d         = e_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    nbits_d     = nbits_q;
    busy_d      = busy_q;
    const_d     = const_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    row_ctrl_o  = '0;
    row_a_o     = p_q;
    row_b_o     = r2_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !busy_q) begin
          busy_d  = 1'b1;
          rem_d   = {1'b0, base_i};
          e_d     = exponent_i[ExpWidth-1:0];
          z_d     = one_m;
          cnt_d   = CntWidth'(InWidth - 1);
          state_d = ST_REDUCE;
        end
      end
      ST_CONST: begin
        if (const_q) begin
          const_d = 1'b0;
          r2_d    = one_m;
          nbits_d = bitlen;
          cnt_d   = '0;
        end else if (cnt_q == CntWidth'(2 * nbits_q)) begin
          busy_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          r2_d  = dsub[ModWidth] ? dbl[ModWidth-1:0] : dsub[ModWidth-1:0];
          cnt_d = cnt_q + CntWidth'(1);
        end
      end
      ST_REDUCE: begin
        // One quotient bit per cycle, most significant first.
        if (rem_q >= mshift && (mshift >> cnt_q) == {1'b0, mod_q}) begin
          rem_d = rsub;
        end
        if (cnt_q == '0) begin
          p_d = rem_d[ModWidth-1:0];
          state_d = (e_q == '0) ? ST_DONE : ST_PM;
          cnt_d = '0;
          row_ctrl_o.start = 1'b0;
        end else begin
          cnt_d = cnt_q - CntWidth'(1);
        end
      end
      ST_PM, ST_ZM, ST_ZMUL, ST_ZOUT, ST_PSQ, ST_POUT: begin
        unique case (state_q)
          ST_PM:   begin row_a_o = p_q;  row_b_o = r2_q; end
          ST_ZM:   begin row_a_o = z_q;  row_b_o = r2_q; end
          ST_ZMUL: begin row_a_o = z_q;  row_b_o = pm_q; end
          ST_ZOUT: begin row_a_o = z_q;  row_b_o = one_m; end
          ST_PSQ:  begin row_a_o = pm_q; row_b_o = pm_q; end
          default: begin row_a_o = p_q;  row_b_o = one_m; end
        endcase
        if (cnt_q == '0) begin
          row_ctrl_o.start = 1'b1;
          cnt_d = CntWidth'(1);
        end else if (!mul_done || cnt_q == '0) begin
          row_ctrl_o.shift = 1'b1;
          cnt_d = cnt_q + CntWidth'(1);
        end else begin
          row_ctrl_o.shift = 1'b1;
          cnt_d = '0;
        end
        if (cnt_q == nbits_q + CntWidth'(1)) begin
          row_ctrl_o = '0;
          cnt_d = '0;
          unique case (state_q)
            ST_PM: begin
              pm_d = row_res_i;
              state_d = e_q[0] ? ST_ZM : ST_PSQ;
            end
            ST_ZM:   begin z_d = row_res_i; state_d = ST_ZMUL; end
            ST_ZMUL: begin z_d = row_res_i; state_d = ST_ZOUT; end
            ST_ZOUT: begin z_d = row_res_i; state_d = ST_PSQ; end
            ST_PSQ:  begin p_d = row_res_i; state_d = ST_POUT; end
            default: begin
              p_d = row_res_i;
              e_d = e_q >> 1;
              if ((e_q >> 1) == '0) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_PM;
              end
            end
          endcase
        end else if (cnt_q == nbits_q) begin
          row_ctrl_o.shift = 1'b1;
          cnt_d = cnt_q + CntWidth'(1);
        end
      end
      ST_DONE: begin
        if (busy_q) begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d = 1'b1;
            out_d = InWidth'(z_q);
            busy_d = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A modulus write restarts the constant computation.
    if (cfg_we_i) begin
      mod_d   = cfg_data_i | ModWidth'(1);
      const_d = 1'b1;
      busy_d  = 1'b1;
      state_d = ST_CONST;
    end
  end

endmodule

[rtl/montgomery_modular_exponentiation.sv]
// ---------------------------------------------------------------------------
// Montgomery modular exponentiation
// Computes base^exponent mod M with a bit-serial Montgomery cell row.
// ---------------------------------------------------------------------------
// One word first has its base reduced, then for each exponent bit up to the
// highest set one, three or six Montgomery products run on the cell row. The
// shared cell row is the limit: one product at a time, one bit of A per cycle.
// After reset and after each modulus write the block computes R^2 mod M, with
// input stalled.
module montgomery_modular_exponentiation
  import mme_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ModWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InWidth-1:0]  base_i,
  input  logic [InWidth-1:0]  exponent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [InWidth-1:0]  power_mod_o
);

  mme_row_ctrl_t       row_ctrl;
  logic [ModWidth-1:0] row_a, row_b, row_m, row_res;

  // Sequencer.
  mme_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .power_mod_o (power_mod_o),
    .row_ctrl_o  (row_ctrl),
    .row_a_o     (row_a),
    .row_b_o     (row_b),
    .row_m_o     (row_m),
    .row_res_i   (row_res)
  );

  // Montgomery cell row.
  mme_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (row_ctrl),
    .a_i    (row_a),
    .b_i    (row_b),
    .m_i    (row_m),
    .res_o  (row_res)
  );

endmodule

[rtl/mme_checker.sv]
// ---------------------------------------------------------------------------
// Port checker
// Watches the ports of the exponentiation block.
// ---------------------------------------------------------------------------
module mme_checker
  import mme_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [InWidth-1:0] power_mod_o
);

  // A stalled word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_mod_o))
    else $error("stalled result changed");

  // An accepted word makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second word");

  // A result comes only while an item is in flight, never the cycle after accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind montgomery_modular_exponentiation mme_checker u_mme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .power_mod_o (power_mod_o)
);
